FILE: hdl/pfpe_pkg.sv
// ============================================================================
// pfpe_pkg: shared definitions for the page framebuffer pixel engine
// Function codes, display command bytes and default geometry.
// ============================================================================
package pfpe_pkg;

    localparam int PAGES_DEFAULT   = 4;
    localparam int COLUMNS_DEFAULT = 128;
    localparam int WORD_BYTES      = 8;

    localparam logic [2:0] FUNC_SET_PIXEL   = 3'd0;
    localparam logic [2:0] FUNC_CLEAR_PIXEL = 3'd1;
    localparam logic [2:0] FUNC_SCROLL      = 3'd2;
    localparam logic [2:0] FUNC_CLEAR_ALL   = 3'd3;
    localparam logic [2:0] FUNC_FILL_ALL    = 3'd4;
    localparam logic [2:0] FUNC_PAINT_PAGE  = 3'd5;

    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CMD_TRAILER   = 8'h10;
    localparam logic [7:0] BYTE_ALL_OFF  = 8'h00;
    localparam logic [7:0] BYTE_ALL_ON   = 8'hff;

endpackage

FILE: hdl/page_framebuffer_pixel_engine_unit.sv
// ============================================================================
// page_framebuffer_pixel_engine_unit: page-organized monochrome frame store
// Set and clear pixels, scroll, clear or fill the store, and stream a page as
// one command transaction, then data transactions of up to eight column bytes.
// ============================================================================
// The pace of every command is set by the single read port and single write
// port of the frame store. A pixel set or clear reads the byte, then writes
// it back. Clear-all and fill-all write every byte of the store, scroll
// moves the store by one page through the same ports, and a paint can be
// held by any output stall. After reset the store is zeroed by a clearing
// pass during which no transaction is taken.
module page_framebuffer_pixel_engine_unit #(
    parameter int PAGES   = pfpe_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = pfpe_pkg::COLUMNS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [4:0]  pixel_row,
    input  logic [6:0]  pixel_col,
    input  logic [1:0]  paint_page,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_bytes,
    output logic [3:0]  byte_count,
    output logic        is_data,
    output logic        last
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam logic [AW-1:0] SCROLL_LIMIT = AW'(DEPTH - COLUMNS);
    localparam logic [AW-1:0] LAST_ADDR    = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COL_END      = CW'(COLUMNS);
    localparam logic [3:0]    FULL_WORD    = 4'(pfpe_pkg::WORD_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_FILL,
        ST_SCROLL,
        ST_CMD,
        ST_PAINT
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    mask_reg, mask_next;
    logic          set_reg, set_next;
    logic [7:0]    fill_reg, fill_next;
    logic          pend_reg, pend_next;
    logic [1:0]    page_reg, page_next;
    logic [CW-1:0] col_reg, col_next;
    logic [3:0]    rd_cnt_reg, rd_cnt_next;
    logic [63:0]   word_reg, word_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_bytes_reg, out_bytes_next;
    logic [3:0]    byte_count_reg, byte_count_next;
    logic          is_data_reg, is_data_next;
    logic          last_reg, last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          pixel_ok;
    logic          page_ok;
    logic [AW-1:0] pixel_addr;
    logic [AW-1:0] paint_addr;
    logic          out_free;
    logic          issue;
    logic          complete;
    logic [3:0]    rd_dec;
    logic [63:0]   word_merged;

    pfpe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pixel_ok   = ({2'b00, pixel_row} < 7'(PAGES * 8))
                        && ({2'b00, pixel_col} < 9'(COLUMNS));
    assign page_ok    = {2'b00, paint_page} < 4'(PAGES);
    assign pixel_addr = AW'(int'(pixel_row[4:3]) * COLUMNS + int'(pixel_col));
    assign paint_addr = AW'(int'(page_reg) * COLUMNS + int'(col_reg));
    assign out_free   = !out_valid_reg || !out_stall;
    assign issue      = (rd_cnt_reg != FULL_WORD) && (col_reg != COL_END);
    assign complete   = !pend_reg && (rd_cnt_reg != 4'd0)
                        && ((rd_cnt_reg == FULL_WORD) || (col_reg == COL_END));
    assign rd_dec     = rd_cnt_reg - 4'd1;
    assign word_merged = word_reg | (64'(ram_rdata) << {rd_dec[2:0], 3'b000});

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        set_next        = set_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        page_next       = page_reg;
        col_next        = col_reg;
        rd_cnt_next     = rd_cnt_reg;
        word_next       = word_reg;
        out_valid_next  = out_valid_reg;
        out_bytes_next  = out_bytes_reg;
        byte_count_next = byte_count_reg;
        is_data_next    = is_data_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = fill_reg;
        ram_raddr       = pixel_addr;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func) inside
                        pfpe_pkg::FUNC_SET_PIXEL, pfpe_pkg::FUNC_CLEAR_PIXEL:
                        begin
                            if (pixel_ok)
                            begin
                                state_next = ST_RMW;
                                addr_next  = pixel_addr;
                                mask_next  = 8'(1) << pixel_row[2:0];
                                set_next   = (func == pfpe_pkg::FUNC_SET_PIXEL);
                            end
                        end
                        pfpe_pkg::FUNC_SCROLL:
                        begin
                            state_next = ST_SCROLL;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                        end
                        pfpe_pkg::FUNC_CLEAR_ALL:
                        begin
                            state_next = ST_FILL;
                            cnt_next   = '0;
                            fill_next  = pfpe_pkg::BYTE_ALL_OFF;
                        end
                        pfpe_pkg::FUNC_FILL_ALL:
                        begin
                            state_next = ST_FILL;
                            cnt_next   = '0;
                            fill_next  = pfpe_pkg::BYTE_ALL_ON;
                        end
                        pfpe_pkg::FUNC_PAINT_PAGE:
                        begin
                            if (page_ok)
                            begin
                                state_next = ST_CMD;
                                page_next  = paint_page;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = set_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_SCROLL:
            begin
                ram_raddr = AW'(int'(cnt_reg) + COLUMNS);
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg != SCROLL_LIMIT)
                begin
                    pend_next = 1'b1;
                    addr_next = cnt_reg;
                    cnt_next  = cnt_reg + AW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bytes_next  = {32'h0, pfpe_pkg::CMD_TRAILER, 8'h00,
                                       6'b000000, page_reg, pfpe_pkg::CMD_PAGE_ADDR};
                    byte_count_next = 4'd4;
                    is_data_next    = 1'b0;
                    last_next       = 1'b0;
                    col_next        = '0;
                    rd_cnt_next     = 4'd0;
                    pend_next       = 1'b0;
                    word_next       = '0;
                    state_next      = ST_PAINT;
                end
            end
            ST_PAINT:
            begin
                ram_raddr = paint_addr;
                if (pend_reg)
                begin
                    word_next = word_merged;
                end
                pend_next = issue;
                if (issue)
                begin
                    col_next    = col_reg + CW'(1);
                    rd_cnt_next = rd_cnt_reg + 4'd1;
                end
                if (complete && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bytes_next  = word_reg;
                    byte_count_next = rd_cnt_reg;
                    is_data_next    = 1'b1;
                    last_next       = (col_reg == COL_END);
                    rd_cnt_next     = 4'd0;
                    word_next       = '0;
                    if (col_reg == COL_END)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            cnt_reg        <= '0;
            addr_reg       <= '0;
            mask_reg       <= '0;
            set_reg        <= 1'b0;
            fill_reg       <= pfpe_pkg::BYTE_ALL_OFF;
            pend_reg       <= 1'b0;
            page_reg       <= '0;
            col_reg        <= '0;
            rd_cnt_reg     <= '0;
            word_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_bytes_reg  <= '0;
            byte_count_reg <= '0;
            is_data_reg    <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            addr_reg       <= addr_next;
            mask_reg       <= mask_next;
            set_reg        <= set_next;
            fill_reg       <= fill_next;
            pend_reg       <= pend_next;
            page_reg       <= page_next;
            col_reg        <= col_next;
            rd_cnt_reg     <= rd_cnt_next;
            word_reg       <= word_next;
            out_valid_reg  <= out_valid_next;
            out_bytes_reg  <= out_bytes_next;
            byte_count_reg <= byte_count_next;
            is_data_reg    <= is_data_next;
            last_reg       <= last_next;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_bytes  = out_bytes_reg;
    assign byte_count = byte_count_reg;
    assign is_data    = is_data_reg;
    assign last       = last_reg;

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> is_data_reg)
        else $error("A final paint transaction is not marked as data.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (byte_count_reg != 4'd0) && (byte_count_reg <= FULL_WORD))
        else $error("The byte count of a result is out of range.");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("The frame store is written while the engine is idle.");

    a_paint_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == pfpe_pkg::FUNC_PAINT_PAGE) && page_ok
        |=> state_reg == ST_CMD)
        else $error("An accepted paint did not start with the command transaction.");

endmodule

FILE: hdl/pfpe_ram.sv
// ============================================================================
// pfpe_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module pfpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: bench/pfpe_frame_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pfpe_frame_checker: frame store predictor and display word checker
// Watches both channels of the pixel engine. Accepted pixel, scroll, clear
// and fill commands update a shadow copy of the frame store, and a paint
// queues the display words it must produce. Each accepted output transaction
// is compared with the oldest queued word, field by field.
// ============================================================================
module pfpe_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  func,
    input  logic [4:0]  pixel_row,
    input  logic [6:0]  pixel_col,
    input  logic [1:0]  paint_page,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] out_bytes,
    input  logic [3:0]  byte_count,
    input  logic        is_data,
    input  logic        last,
    output int          mismatch_count,
    output int          pending_words,
    output int          words_checked
);

    localparam int PAGES       = pfpe_pkg::PAGES_DEFAULT;
    localparam int COLUMNS     = pfpe_pkg::COLUMNS_DEFAULT;
    localparam int STORE_BYTES = PAGES * COLUMNS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        is_data;
        logic        last;
    } disp_word_t;

    logic [7:0] shadow_frame [STORE_BYTES];
    disp_word_t expected_words [$];

    task automatic apply_command(input logic [2:0] f, input logic [4:0] r,
                                 input logic [6:0] c, input logic [1:0] pg);
        int idx;
        int n;
        logic [7:0] mask;
        disp_word_t w;
        case (f) inside
            pfpe_pkg::FUNC_SET_PIXEL, pfpe_pkg::FUNC_CLEAR_PIXEL:
            begin
                if (r < PAGES * 8 && c < COLUMNS)
                begin
                    idx  = (r >> 3) * COLUMNS + c;
                    mask = 8'h01 << r[2:0];
                    if (f == pfpe_pkg::FUNC_SET_PIXEL)
                        shadow_frame[idx] = shadow_frame[idx] | mask;
                    else
                        shadow_frame[idx] = shadow_frame[idx] & ~mask;
                end
            end
            pfpe_pkg::FUNC_SCROLL:
            begin
                for (int i = 0; i < (PAGES - 1) * COLUMNS; i++)
                    shadow_frame[i] = shadow_frame[i + COLUMNS];
            end
            pfpe_pkg::FUNC_CLEAR_ALL:
            begin
                foreach (shadow_frame[i])
                    shadow_frame[i] = pfpe_pkg::BYTE_ALL_OFF;
            end
            pfpe_pkg::FUNC_FILL_ALL:
            begin
                foreach (shadow_frame[i])
                    shadow_frame[i] = pfpe_pkg::BYTE_ALL_ON;
            end
            pfpe_pkg::FUNC_PAINT_PAGE:
            begin
                if (pg < PAGES)
                begin
                    w.bytes   = {32'd0, pfpe_pkg::CMD_TRAILER, pfpe_pkg::BYTE_ALL_OFF,
                                 8'(pg), pfpe_pkg::CMD_PAGE_ADDR};
                    w.count   = 4'd4;
                    w.is_data = 1'b0;
                    w.last    = 1'b0;
                    expected_words.push_back(w);
                    for (int col = 0; col < COLUMNS; col += 8)
                    begin
                        w = '0;
                        n = 0;
                        while (n < 8 && col + n < COLUMNS)
                        begin
                            w.bytes[8 * n +: 8] = shadow_frame[pg * COLUMNS + col + n];
                            n++;
                        end
                        w.count   = 4'(n);
                        w.is_data = 1'b1;
                        w.last    = (col + 8 >= COLUMNS);
                        expected_words.push_back(w);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_word(input disp_word_t got);
        disp_word_t want;
        if (expected_words.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: unexpected display word bytes=%h count=%0d dc=%b last=%b",
                         $realtime, got.bytes, got.count, got.is_data, got.last);
        end
        else
        begin
            want = expected_words.pop_front();
            words_checked++;
            if (got.bytes !== want.bytes || got.count !== want.count ||
                got.is_data !== want.is_data || got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: display word %0d mismatch", $realtime, words_checked);
                    $display("    expected bytes=%h count=%0d dc=%b last=%b",
                             want.bytes, want.count, want.is_data, want.last);
                    $display("    actual   bytes=%h count=%0d dc=%b last=%b",
                             got.bytes, got.count, got.is_data, got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_frame[i])
                shadow_frame[i] = pfpe_pkg::BYTE_ALL_OFF;
            expected_words.delete();
            mismatch_count = 0;
            words_checked  = 0;
            pending_words  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_command(func, pixel_row, pixel_col, paint_page);
            if (out_valid && !out_stall)
                check_word({out_bytes, byte_count, is_data, last});
            pending_words = expected_words.size();
        end
    end

endmodule

FILE: bench/tb_page_framebuffer_pixel_engine_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_page_framebuffer_pixel_engine_unit: testbench for the pixel engine
// Drives pixel, scroll, clear, fill and paint commands in random bursts while
// the display side stalls in changing patterns. A separate checker predicts
// every display word and counts mismatches; this module gives the verdict.
// ============================================================================
module tb_page_framebuffer_pixel_engine_unit;

    localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;
    localparam int RANDOM_ITEMS = 330;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [4:0]  pixel_row;
    logic [6:0]  pixel_col;
    logic [1:0]  paint_page;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        is_data;
    logic        last;

    int mismatch_count;
    int pending_words;
    int words_checked;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_mode_cycles = 0;
    int op_count [8];
    int cycle_count = 0;

    always #10 clk = ~clk;

    page_framebuffer_pixel_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .pixel_row  (pixel_row),
        .pixel_col  (pixel_col),
        .paint_page (paint_page),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_bytes  (out_bytes),
        .byte_count (byte_count),
        .is_data    (is_data),
        .last       (last)
    );

    pfpe_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pixel_row      (pixel_row),
        .pixel_col      (pixel_col),
        .paint_page     (paint_page),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_bytes      (out_bytes),
        .byte_count     (byte_count),
        .is_data        (is_data),
        .last           (last),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words),
        .words_checked  (words_checked)
    );

    always @(negedge clk)
    begin
        if (rx_mode_cycles == 0)
        begin
            rx_mode        = $urandom_range(0, 2);
            rx_mode_cycles = $urandom_range(50, 300);
        end
        else
            rx_mode_cycles--;
        case (rx_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_cmd(input logic [2:0] f, input logic [4:0] r,
                            input logic [6:0] c, input logic [1:0] pg);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                in_valid   <= 1'b0;
                func       <= 3'($urandom);
                pixel_row  <= 5'($urandom);
                pixel_col  <= 7'($urandom);
                paint_page <= 2'($urandom);
                @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid   <= 1'b1;
        func       <= f;
        pixel_row  <= r;
        pixel_col  <= c;
        paint_page <= pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        op_count[f]++;
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_cmd(pfpe_pkg::FUNC_SET_PIXEL, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_SET_PIXEL, 5'd31, 7'd127, 2'd3);
        send_cmd(pfpe_pkg::FUNC_SET_PIXEL, 5'd7, 7'd5, 2'd0);
        send_cmd(pfpe_pkg::FUNC_SET_PIXEL, 5'd8, 7'd5, 2'd0);
        send_cmd(pfpe_pkg::FUNC_SET_PIXEL, 5'd15, 7'd64, 2'd1);
        send_cmd(pfpe_pkg::FUNC_SET_PIXEL, 5'd26, 7'd77, 2'd2);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd31, 7'd127, 2'd3);
        send_cmd(pfpe_pkg::FUNC_CLEAR_PIXEL, 5'd31, 7'd127, 2'd0);
        send_cmd(pfpe_pkg::FUNC_CLEAR_PIXEL, 5'd26, 7'd76, 2'd0);
        send_cmd(pfpe_pkg::FUNC_SCROLL, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd0, 7'd0, 2'd3);
        send_cmd(pfpe_pkg::FUNC_FILL_ALL, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_CLEAR_PIXEL, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_CLEAR_PIXEL, 5'd23, 7'd100, 2'd0);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd0, 7'd0, 2'd2);
        send_cmd(FUNC_UNUSED_6, 5'd31, 7'd127, 2'd3);
        send_cmd(FUNC_UNUSED_7, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_CLEAR_ALL, 5'd0, 7'd0, 2'd0);
        send_cmd(pfpe_pkg::FUNC_PAINT_PAGE, 5'd0, 7'd0, 2'd1);
    endtask

    task automatic run_random();
        int counted;
        int pick;
        logic [2:0] f;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                f = pfpe_pkg::FUNC_SET_PIXEL;
            else if (pick < 58)
                f = pfpe_pkg::FUNC_CLEAR_PIXEL;
            else if (pick < 80)
                f = pfpe_pkg::FUNC_PAINT_PAGE;
            else if (pick < 87)
                f = pfpe_pkg::FUNC_SCROLL;
            else if (pick < 91)
                f = pfpe_pkg::FUNC_CLEAR_ALL;
            else if (pick < 95)
                f = pfpe_pkg::FUNC_FILL_ALL;
            else
                f = ($urandom_range(0, 1) == 1) ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
            send_cmd(f, 5'($urandom), 7'($urandom), 2'($urandom));
            if (f != FUNC_UNUSED_6 && f != FUNC_UNUSED_7)
                counted++;
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_page_framebuffer_pixel_engine_unit NOT OK");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = pfpe_pkg::FUNC_SET_PIXEL;
        pixel_row  = 5'd0;
        pixel_col  = 7'd0;
        paint_page = 2'd0;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Commands: %0d set, %0d clear, %0d scroll, %0d clear-all, %0d fill,",
                 op_count[pfpe_pkg::FUNC_SET_PIXEL], op_count[pfpe_pkg::FUNC_CLEAR_PIXEL],
                 op_count[pfpe_pkg::FUNC_SCROLL], op_count[pfpe_pkg::FUNC_CLEAR_ALL],
                 op_count[pfpe_pkg::FUNC_FILL_ALL]);
        $display("    %0d paint, %0d unused.", op_count[pfpe_pkg::FUNC_PAINT_PAGE],
                 op_count[FUNC_UNUSED_6] + op_count[FUNC_UNUSED_7]);
        $display("Display words compared: %0d, mismatches: %0d.", words_checked, mismatch_count);
        if (mismatch_count == 0 && pending_words == 0)
            $display("tb_page_framebuffer_pixel_engine_unit OK");
        else
            $display("tb_page_framebuffer_pixel_engine_unit NOT OK");
        $finish;
    end

endmodule
